### hdl/bet_pkg.sv
// Shared types, codes and character-class helpers for the tokenizer.
package bet_pkg;

  typedef enum logic [3:0] {
    TK_IDENT = 4'd0,
    TK_TRUE  = 4'd1,
    TK_FALSE = 4'd2,
    TK_NOT   = 4'd3,
    TK_OR    = 4'd4,
    TK_AND   = 4'd5,
    TK_QMARK = 4'd6,
    TK_COLON = 4'd7,
    TK_LPAR  = 4'd8,
    TK_RPAR  = 4'd9,
    TK_EOF   = 4'd10,
    TK_ERROR = 4'd11
  } tok_kind_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_PREFIX = 2'd1,
    PH_IDENT  = 2'd2
  } scan_phase_t;

  typedef enum logic {
    FN_CHAR = 1'b0,
    FN_END  = 1'b1
  } func_t;

  localparam int KwSlots   = 5;
  localparam int RunMax    = 7;
  localparam int FifoDepth = 4;

  localparam logic [7:0] ChUnder = "_";
  localparam logic [7:0] ChQmark = "?";
  localparam logic [7:0] ChColon = ":";
  localparam logic [7:0] ChLpar  = "(";
  localparam logic [7:0] ChRpar  = ")";

  // tokens raised by one word, in order
  typedef struct packed {
    logic [1:0] cnt;
    tok_kind_t  k0;
    tok_kind_t  k1;
  } tok_pair_t;

  typedef struct packed {
    tok_kind_t kind;
    logic      last;
  } tok_entry_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage

### hdl/bet_if.sv
// Valid/ready channel interfaces for the tokenizer input and token output.
interface bet_in_if;
  logic                  valid;
  logic                  ready;
  logic                  func;
  logic [7:0]            ch;
  modport source (output valid, output func, output ch, input ready);
  modport sink   (input valid, input func, input ch, output ready);
endinterface

interface bet_out_if;
  logic                  valid;
  logic                  ready;
  logic [3:0]            token_kind;
  logic                  last_of_run;
  modport source (output valid, output token_kind, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input last_of_run, output ready);
endinterface

### hdl/bet_core.sv
// Scan state, lexeme buffer and per-word token decision.
module bet_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic              func,
  input  logic [7:0]        ch,
  output bet_pkg::tok_pair_t toks
);
  import bet_pkg::*;

  scan_phase_t phase, phase_next;
  logic [2:0]  len, len_next;
  logic [7:0]  kc [KwSlots];
  logic        kc_we;
  logic [2:0]  kc_idx;

  tok_kind_t   close_kind;
  logic        close_has;
  tok_kind_t   fresh_kind;
  logic        fresh_has;
  logic        is_end;

  // keyword match over the stored prefix
  always_comb begin
    close_kind = TK_IDENT;
    if (len == 3'd2 && kc[0] == "o" && kc[1] == "r") begin
      close_kind = TK_OR;
    end else if (len == 3'd3 && kc[0] == "a" && kc[1] == "n" && kc[2] == "d") begin
      close_kind = TK_AND;
    end else if (len == 3'd3 && kc[0] == "n" && kc[1] == "o" && kc[2] == "t") begin
      close_kind = TK_NOT;
    end else if (len == 3'd5 && kc[0] == "f" && kc[1] == "a" && kc[2] == "l"
                 && kc[3] == "s" && kc[4] == "e") begin
      close_kind = TK_FALSE;
    end else if (len == 3'd4 && kc[0] == "t" && kc[1] == "r" && kc[2] == "u"
                 && kc[3] == "e") begin
      close_kind = TK_TRUE;
    end
    if (phase == PH_PREFIX) begin
      close_kind = TK_ERROR;
    end
  end

  always_comb begin
    is_end     = (func == FN_END);
    phase_next = phase;
    len_next   = len;
    kc_we      = 1'b0;
    kc_idx     = len;
    close_has  = 1'b0;
    fresh_has  = 1'b0;
    fresh_kind = TK_ERROR;

    if (is_end) begin
      close_has  = (phase == PH_PREFIX) || (phase == PH_IDENT);
      fresh_has  = 1'b1;
      fresh_kind = TK_EOF;
      phase_next = PH_IDLE;
      len_next   = 3'd0;
    end else if ((phase == PH_PREFIX && (is_digit(ch) || ch == ChUnder || is_letter(ch)))
                 || (phase == PH_IDENT
                     && (is_letter(ch) || is_digit(ch) || ch == ChUnder))) begin
      // run continues
      kc_we = (len < 3'(KwSlots));
      if (len < 3'(RunMax)) begin
        len_next = len + 3'd1;
      end
      if (is_letter(ch)) begin
        phase_next = PH_IDENT;
      end
    end else begin
      // run ends (if open); the word is then taken fresh
      close_has  = (phase == PH_PREFIX) || (phase == PH_IDENT);
      phase_next = PH_IDLE;
      len_next   = 3'd0;
      if (is_letter(ch) || ch == ChUnder) begin
        phase_next = is_letter(ch) ? PH_IDENT : PH_PREFIX;
        len_next   = 3'd1;
        kc_we      = 1'b1;
        kc_idx     = 3'd0;
      end else if (!is_space(ch)) begin
        fresh_has = 1'b1;
        case (ch)
          ChQmark: fresh_kind = TK_QMARK;
          ChColon: fresh_kind = TK_COLON;
          ChLpar:  fresh_kind = TK_LPAR;
          ChRpar:  fresh_kind = TK_RPAR;
          default: fresh_kind = TK_ERROR;
        endcase
      end
    end

    toks.cnt = {1'b0, close_has} + {1'b0, fresh_has};
    toks.k0  = close_has ? close_kind : fresh_kind;
    toks.k1  = fresh_kind;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      len   <= 3'd0;
    end else if (take) begin
      phase <= phase_next;
      len   <= len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && kc_we) begin
      kc[kc_idx] <= ch;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) == (len == 3'd0))
    else $error("run length and scan phase disagree");

  a_eof_resets: assert property (@(posedge clk) disable iff (rst)
    take && func == FN_END |=> phase == PH_IDLE && len == 3'd0)
    else $error("scanner not idle after end of input");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    toks.cnt != 2'd3)
    else $error("more than two tokens for one word");
`endif

endmodule

### hdl/boolean_expression_tokenizer_unit.sv
// Top level of the boolean-expression tokenizer: scanner plus token queue.
//
//  channel | dir | payload                      | word
//  req     | in  | func[0], ch[7:0]             | one character or end marker
//  rsp     | out | token_kind[3:0], last_of_run | one token
//
// One input word is taken per cycle while the token queue has room for two
// tokens; its tokens (zero, one or two) land in the queue in the same edge.
// Tokens leave at one per cycle while rsp.ready is high, so words that raise two
// tokens can fill the queue; sustained rate is one word per cycle otherwise.
// Synchronous active-high reset idles the scanner and empties the queue.
// A stalled rsp backs up into the 4-entry queue, then drops req.ready.
module boolean_expression_tokenizer_unit (
  input  logic     clk,
  input  logic     rst,
  bet_in_if.sink   req,
  bet_out_if.source rsp
);
  import bet_pkg::*;

  localparam int PtrW = $clog2(FifoDepth);
  localparam int CntW = $clog2(FifoDepth + 1);

  tok_pair_t   toks;
  logic        take;
  logic        pop;

  // token queue
  tok_entry_t  q [FifoDepth];
  logic [PtrW-1:0] head, tail;
  logic [CntW-1:0] count, count_next;

  // room for the worst case of two tokens
  assign req.ready = (count <= CntW'(FifoDepth - 2));
  assign take      = req.valid && req.ready;

  bet_core u_core (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .func (req.func),
    .ch   (req.ch),
    .toks (toks)
  );

  assign rsp.valid       = (count != '0);
  assign rsp.token_kind  = q[head].kind;
  assign rsp.last_of_run = q[head].last;
  assign pop             = rsp.valid && rsp.ready;

  always_comb begin
    count_next = count;
    if (take) begin
      count_next = count_next + CntW'(toks.cnt);
    end
    if (pop) begin
      count_next = count_next - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (pop) begin
        head <= head + PtrW'(1);
      end
      if (take) begin
        tail <= tail + PtrW'(toks.cnt);
      end
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (take && toks.cnt != 2'd0) begin
      q[tail] <= '{kind: toks.k0, last: (toks.cnt == 2'd1)};
    end
    if (take && toks.cnt == 2'd2) begin
      q[tail + PtrW'(1)] <= '{kind: toks.k1, last: 1'b1};
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(FifoDepth))
    else $error("token queue overflow");

  a_eof_queued: assert property (@(posedge clk) disable iff (rst)
    take && req.func == FN_END |=> count != '0)
    else $error("end of input left no token");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    PtrW'(tail - head) == PtrW'(count))
    else $error("queue pointers disagree with count");
`endif

endmodule
